// ===== sv/uctc_pkg.sv =====
// Shared types, constants and the CJK range check for the UTF-8 text classifier.
package uctc_pkg;

  localparam int unsigned CodeW = 21;

  typedef logic [CodeW-1:0] code_t;

  typedef struct packed {
    logic [1:0] pending;
    code_t      acc;
    logic       stopped;
    logic       cjk_seen;
    logic       non_ascii;
    logic       first_done;
    logic       first_ok;
    code_t      first_code;
  } uctc_state_t;

  localparam uctc_state_t StateClear = '0;

  localparam code_t HangulJamoLo   = 21'h01100;
  localparam code_t HangulJamoHi   = 21'h011FF;
  localparam code_t CjkPunctLo     = 21'h03000;
  localparam code_t CjkPunctHi     = 21'h0303F;
  localparam code_t HangulCompatLo = 21'h03130;
  localparam code_t HangulCompatHi = 21'h0318F;
  localparam code_t CjkUnifiedLo   = 21'h03400;
  localparam code_t CjkUnifiedHi   = 21'h09FFF;
  localparam code_t HangulSylLo    = 21'h0AC00;
  localparam code_t HangulSylHi    = 21'h0D7AF;
  localparam code_t CjkCompatLo    = 21'h0F900;
  localparam code_t CjkCompatHi    = 21'h0FAFF;
  localparam code_t FullwidthLo    = 21'h0FF00;
  localparam code_t FullwidthHi    = 21'h0FFEF;
  localparam code_t CjkExtLo       = 21'h20000;
  localparam code_t CjkExtHi       = 21'h2EBEF;

  function automatic logic in_cjk_range(input code_t c);
    return (c >= HangulJamoLo   && c <= HangulJamoHi)   ||
           (c >= CjkPunctLo     && c <= CjkPunctHi)     ||
           (c >= HangulCompatLo && c <= HangulCompatHi) ||
           (c >= CjkUnifiedLo   && c <= CjkUnifiedHi)   ||
           (c >= HangulSylLo    && c <= HangulSylHi)    ||
           (c >= CjkCompatLo    && c <= CjkCompatHi)    ||
           (c >= FullwidthLo    && c <= FullwidthHi)    ||
           (c >= CjkExtLo       && c <= CjkExtHi);
  endfunction

endpackage

// ===== sv/uctc_step.sv =====
// One-byte UTF-8 decode step: next scan state from the current state and a byte.
module uctc_step import uctc_pkg::*; (
  input  uctc_state_t cur,
  input  logic [7:0]  text_byte,
  output uctc_state_t nxt
);

  code_t acc_shift;

  assign acc_shift = {cur.acc[CodeW-7:0], text_byte[5:0]};

  always_comb begin
    nxt = cur;
    if (text_byte[7]) begin
      nxt.non_ascii = 1'b1;
    end
    if (!cur.stopped) begin
      if (cur.pending != 2'd0) begin
        if (text_byte[7:6] != 2'b10) begin
          nxt.stopped = 1'b1;
          nxt.pending = 2'd0;
          nxt.acc     = '0;
          if (!cur.first_done) begin
            nxt.first_done = 1'b1;
            nxt.first_ok   = 1'b0;
            nxt.first_code = '0;
          end
        end else begin
          nxt.pending = cur.pending - 2'd1;
          if (cur.pending == 2'd1) begin
            nxt.acc = '0;
            if (in_cjk_range(acc_shift)) begin
              nxt.cjk_seen = 1'b1;
            end
            if (!cur.first_done) begin
              nxt.first_done = 1'b1;
              nxt.first_ok   = 1'b1;
              nxt.first_code = acc_shift;
            end
          end else begin
            nxt.acc = acc_shift;
          end
        end
      end else if (text_byte[7]) begin
        priority if (text_byte[7:5] == 3'b110) begin
          nxt.pending = 2'd1;
          nxt.acc     = code_t'(text_byte[4:0]);
        end else if (text_byte[7:4] == 4'b1110) begin
          nxt.pending = 2'd2;
          nxt.acc     = code_t'(text_byte[3:0]);
        end else if (text_byte[7:3] == 5'b11110) begin
          nxt.pending = 2'd3;
          nxt.acc     = code_t'(text_byte[2:0]);
        end else begin
          if (!cur.first_done) begin
            nxt.first_done = 1'b1;
            nxt.first_ok   = 1'b0;
            nxt.first_code = '0;
          end
        end
      end
    end
  end

endmodule

// ===== sv/utf8_cjk_text_classifier.sv =====
// Top level of the UTF-8 text classifier with stream handshakes.
// Takes one byte of a UTF-8 string per clock and gives one result after the byte marked
// by s_tlast: whether a CJK/Hangul/fullwidth code point was decoded, whether the string
// was all ASCII, and the first non-ASCII code point with its valid flag. A byte is held in
// the input register and folded into the scan state when it advances; for the last byte the
// result register is loaded at that same edge. The combinational decode step sets a rate of
// one byte per clock, but the byte marked by s_tlast waits in the input register while the
// previous result is still unread. The scan state clears after every string.
module utf8_cjk_text_classifier import uctc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] contains_cjk, [1] all_ascii,
                                 // [2] first_code_valid, [23:3] first_codepoint
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        in_advance;
  logic        out_free;
  logic        res_valid;
  uctc_state_t state;
  uctc_state_t state_next;
  uctc_state_t step_out;
  logic        first_valid;

  uctc_step u_step (
    .cur       (state),
    .text_byte (in_byte),
    .nxt       (step_out)
  );

  assign out_free    = !m_tvalid || m_tready;
  assign in_advance  = in_valid && (!in_last || out_free);
  assign s_tready    = !in_valid || in_advance;
  assign first_valid = step_out.first_done && step_out.first_ok;

  always_comb begin
    state_next = state;
    if (in_advance) begin
      state_next = in_last ? StateClear : step_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      state    <= StateClear;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      state <= state_next;
      if (in_advance && in_last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign res_valid = in_advance && in_last;

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
    if (res_valid) begin
      m_tdata <= {first_valid ? step_out.first_code : code_t'(0),
                  first_valid, !step_out.non_ascii, step_out.cjk_seen};
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the UTF-8 text classifier: byte streams in, one class per string out.
module tb_top import uctc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    code_t codepoint;
    logic  code_valid;
    logic  all_ascii;
    logic  has_cjk;
  } text_class_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;  // [7:0] text_byte
  logic        s_tlast = 1'b0;   // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [0] contains_cjk, [1] all_ascii,
                                 // [2] first_code_valid, [23:3] first_codepoint

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned error_count = 0;

  text_class_t class_q[$];
  logic [7:0]  text_buf[$];

  // predictor state
  logic [1:0] conts_left;
  code_t      code_acc;
  bit         decode_halted;
  bit         cjk_hit;
  bit         high_byte_seen;
  bit         first_fixed;
  bit         first_good;
  code_t      first_cp;

  code_t cjk_lo[8] = '{HangulJamoLo, CjkPunctLo, HangulCompatLo, CjkUnifiedLo,
                       HangulSylLo, CjkCompatLo, FullwidthLo, CjkExtLo};
  code_t cjk_hi[8] = '{HangulJamoHi, CjkPunctHi, HangulCompatHi, CjkUnifiedHi,
                       HangulSylHi, CjkCompatHi, FullwidthHi, CjkExtHi};

  utf8_cjk_text_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic bit code_is_cjk(input code_t c);
    for (int i = 0; i < 8; i++) begin
      if (c >= cjk_lo[i] && c <= cjk_hi[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_text_state();
    conts_left = 2'd0;
    code_acc = '0;
    decode_halted = 1'b0;
    cjk_hit = 1'b0;
    high_byte_seen = 1'b0;
    first_fixed = 1'b0;
    first_good = 1'b0;
    first_cp = '0;
  endfunction

  function automatic void fix_first(input bit ok, input code_t c);
    if (!first_fixed) begin
      first_fixed = 1'b1;
      first_good = ok;
      first_cp = ok ? c : '0;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    if (b[7]) high_byte_seen = 1'b1;
    if (decode_halted) return;
    if (conts_left != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        decode_halted = 1'b1;
        conts_left = 2'd0;
        code_acc = '0;
        fix_first(1'b0, '0);
      end else begin
        code_acc = {code_acc[CodeW-7:0], b[5:0]};
        conts_left = conts_left - 2'd1;
        if (conts_left == 2'd0) begin
          if (code_is_cjk(code_acc)) cjk_hit = 1'b1;
          fix_first(1'b1, code_acc);
          code_acc = '0;
        end
      end
    end else if (b[7]) begin
      if (b[7:5] == 3'b110) begin
        conts_left = 2'd1;
        code_acc = code_t'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        conts_left = 2'd2;
        code_acc = code_t'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        conts_left = 2'd3;
        code_acc = code_t'(b[2:0]);
      end else begin
        fix_first(1'b0, '0);
      end
    end
  endfunction

  function automatic void classify_byte(input logic [7:0] b, input bit last);
    text_class_t res;
    decode_byte(b);
    if (last) begin
      if (conts_left != 2'd0) fix_first(1'b0, '0);
      res.has_cjk = cjk_hit;
      res.all_ascii = !high_byte_seen;
      res.code_valid = first_fixed && first_good;
      res.codepoint = (first_fixed && first_good) ? first_cp : '0;
      class_q.push_back(res);
      clear_text_state();
    end
  endfunction

  // one request per byte; valid stays high across back-to-back bytes
  task automatic drive_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    classify_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      drive_byte(text_buf[i], i == text_buf.size() - 1);
    end
  endtask

  task automatic push_code(input code_t cp, input int unsigned len);
    case (len)
      2: begin
        text_buf.push_back({3'b110, cp[10:6]});
        text_buf.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_buf.push_back({4'b1110, cp[15:12]});
        text_buf.push_back({2'b10, cp[11:6]});
        text_buf.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_buf.push_back({5'b11110, cp[20:18]});
        text_buf.push_back({2'b10, cp[17:12]});
        text_buf.push_back({2'b10, cp[11:6]});
        text_buf.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic int unsigned code_len(input code_t cp);
    if (cp < 21'h00800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  task automatic push_random_token();
    int unsigned pick;
    int unsigned len;
    int unsigned k;
    code_t cp;
    pick = $urandom_range(99);
    if (pick < 25) begin
      text_buf.push_back(8'($urandom_range(1, 127)));
    end else if (pick < 65) begin
      k = $urandom_range(15);
      cp = k[0] ? cjk_hi[k >> 1] : cjk_lo[k >> 1];
      cp = cp + code_t'($urandom_range(2)) - code_t'(1);
      len = code_len(cp);
      if (len < 4 && $urandom_range(9) == 0) len++;
      push_code(cp, len);
    end else if (pick < 80) begin
      len = $urandom_range(2, 4);
      case (len)
        2: cp = code_t'($urandom_range(21'h007FF));
        3: cp = code_t'($urandom_range(21'h0FFFF));
        default: cp = code_t'($urandom_range(21'h1FFFFF));
      endcase
      push_code(cp, len);
    end else if (pick < 88) begin
      text_buf.push_back(8'($urandom_range(128, 255)));
    end else if (pick < 95) begin
      // lead, zero or more good continuations (fewer than needed), then a byte that is not a continuation
      len = $urandom_range(2, 4);
      push_code(code_t'($urandom_range(21'h1FFFFF)), len);
      k = $urandom_range(1, len - 1);
      repeat (k) void'(text_buf.pop_back());
      if ($urandom_range(1)) text_buf.push_back(8'($urandom_range(1, 127)));
      else text_buf.push_back(8'($urandom_range(8'hC0, 8'hFF)));
    end else begin
      // cut-off sequence
      len = $urandom_range(2, 4);
      push_code(code_t'($urandom_range(21'h1FFFFF)), len);
      k = $urandom_range(1, len - 1);
      repeat (k) void'(text_buf.pop_back());
    end
  endtask

  task automatic test_ascii_extremes();
    text_buf = {8'h01, 8'h7F};
    send_text();
    text_buf = {8'hFF};
    send_text();
    text_buf = {8'h80};
    send_text();
  endtask

  task automatic test_valid_sequences();
    text_buf = {8'hC3, 8'hA9};
    send_text();
    text_buf = {8'hE4, 8'hB8, 8'h80};
    send_text();
    text_buf = {8'hF0, 8'hA0, 8'h80, 8'h80};
    send_text();
    text_buf = {8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_text();
  endtask

  task automatic test_broken_sequences();
    // bad continuation halts decoding, later CJK is not counted
    text_buf = {8'hE4, 8'h41, 8'hE4, 8'hB8, 8'h80};
    send_text();
    text_buf = {8'hE4, 8'hB8};
    send_text();
  endtask

  task automatic test_random_text(input int unsigned byte_goal, input int unsigned src_pct,
                                  input int unsigned snk_pct);
    int unsigned sent;
    int unsigned tokens;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < byte_goal) begin
      text_buf.delete();
      tokens = $urandom_range(1, 6);
      repeat (tokens) push_random_token();
      sent += text_buf.size();
      send_text();
    end
  endtask

  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    text_class_t got;
    text_class_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = text_class_t'(m_tdata);
      if (class_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, m_tdata);
        error_count++;
      end else begin
        want = class_q.pop_front();
        if (got.has_cjk !== want.has_cjk) begin
          $display("%0t: contains_cjk expected %0d actual %0d",
                   $realtime, want.has_cjk, got.has_cjk);
          error_count++;
        end
        if (got.all_ascii !== want.all_ascii) begin
          $display("%0t: all_ascii expected %0d actual %0d",
                   $realtime, want.all_ascii, got.all_ascii);
          error_count++;
        end
        if (got.code_valid !== want.code_valid) begin
          $display("%0t: first_code_valid expected %0d actual %0d",
                   $realtime, want.code_valid, got.code_valid);
          error_count++;
        end
        if (got.codepoint !== want.codepoint) begin
          $display("%0t: first_codepoint expected %h actual %h",
                   $realtime, want.codepoint, got.codepoint);
          error_count++;
        end
      end
    end
  end

  initial begin
    clear_text_state();
    src_idle_pct = 22;
    snk_idle_pct = 49;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_ascii_extremes();
    test_valid_sequences();
    test_broken_sequences();
    test_random_text(170, 22, 49);
    test_random_text(170, 49, 22);
    test_random_text(170, 0, 0);
    s_tvalid <= 1'b0;
    while (class_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
